[rtl/maximum_suffix_finder_defines.svh]
// Assertion macros for the maximum suffix finder
`ifndef MAXIMUM_SUFFIX_FINDER_DEFINES_SVH
`define MAXIMUM_SUFFIX_FINDER_DEFINES_SVH

// same-cycle implication
`define MSF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define MSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/msf_pkg.sv]
package msf_pkg;

    localparam int MAX_LEN = 4096;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;

    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    typedef struct packed {
        logic start;
        logic ack;
    } t_scan_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_stat;

endpackage

[rtl/msf_ram.sv]
module msf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [DATA_W-1:0]          i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr_b,
    output logic [DATA_W-1:0]          o_rd_data_a,
    output logic [DATA_W-1:0]          o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[rtl/msf_scan.sv]
module msf_scan import msf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_scan_ctl         i_ctl,
    input  logic [CNT_W-1:0]  i_count,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr_a,
    output logic [ADDR_W-1:0] o_rd_addr_b,
    input  logic [CHAR_W-1:0] i_rd_data_a,
    input  logic [CHAR_W-1:0] i_rd_data_b,
    output t_scan_stat        o_stat,
    output logic [ADDR_W-1:0] o_best
);

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_READ = 4'b0010,
        SC_CMP  = 4'b0100,
        SC_DONE = 4'b1000
    } t_sc_state;

    t_sc_state          r_state, n_state;
    logic [ADDR_W-1:0]  r_best,  n_best;
    logic [CNT_W-1:0]   r_probe, n_probe;
    logic [CNT_W-1:0]   r_off,   n_off;

    logic [CNT_W:0] sum_a;
    logic [CNT_W:0] sum_b;
    logic [CNT_W:0] skip;
    logic [CNT_W:0] best_max;
    logic           more;

    assign sum_a    = {1'b0, CNT_W'(r_best)} + {1'b0, r_off};
    assign sum_b    = {1'b0, r_probe} + {1'b0, r_off};
    assign skip     = sum_a + (CNT_W+1)'(1);
    assign best_max = (skip > {1'b0, r_probe}) ? skip : {1'b0, r_probe};
    assign more     = sum_b < {1'b0, i_count};

    assign o_rd_en     = (r_state == SC_READ) && more;
    assign o_rd_addr_a = sum_a[ADDR_W-1:0];
    assign o_rd_addr_b = sum_b[ADDR_W-1:0];

    always_comb begin
        n_state = r_state;
        n_best  = r_best;
        n_probe = r_probe;
        n_off   = r_off;
        unique case (r_state)
            SC_IDLE: begin
                if (i_ctl.start) begin
                    n_best  = '0;
                    n_probe = CNT_W'(1);
                    n_off   = '0;
                    n_state = SC_READ;
                end
            end
            SC_READ: begin
                n_state = more ? SC_CMP : SC_DONE;
            end
            SC_CMP: begin
                if (i_rd_data_a == i_rd_data_b) begin
                    n_off = r_off + CNT_W'(1);
                end else if (i_rd_data_a < i_rd_data_b) begin
                    n_best  = best_max[ADDR_W-1:0];
                    n_probe = CNT_W'(best_max[ADDR_W-1:0]) + CNT_W'(1);
                    n_off   = '0;
                end else begin
                    n_probe = sum_b[CNT_W-1:0] + CNT_W'(1);
                    n_off   = '0;
                end
                n_state = SC_READ;
            end
            SC_DONE: begin
                if (i_ctl.ack) begin
                    n_state = SC_IDLE;
                end
            end
            default: n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_best  <= '0;
            r_probe <= CNT_W'(1);
            r_off   <= '0;
        end else begin
            r_state <= n_state;
            r_best  <= n_best;
            r_probe <= n_probe;
            r_off   <= n_off;
        end
    end

    assign o_stat.busy = (r_state == SC_READ) || (r_state == SC_CMP);
    assign o_stat.done = (r_state == SC_DONE);
    assign o_best      = r_best;

endmodule

[rtl/maximum_suffix_finder.sv]
// Maximum suffix finder.
// Input stream: one character per transaction, tdata[7:0] = char_byte,
// tlast = last_char. Bytes are written to a 4096-entry character store;
// bytes beyond that are dropped and the result is flagged.
// After the final byte the two-pointer scan runs over the stored string.
// Each comparison reads two store entries through the dual read port
// (SC_READ) and compares them (SC_CMP); a string of n bytes needs
// fewer than 2n comparisons. Loading accepts one byte per cycle.
// Input tready is low while the scan runs and while a finished scan
// waits for the output register.
// Output: one transaction per string, tdata[11:0] = start_index,
// tdata[24:12] = suffix_length, tuser[0] = overflowed.
// The result sits in an output register: while the receiver stalls, the
// next string is still loaded; only a second result waits for it.
// Reset (synchronous, active low) empties the string, stops the scan and
// drops any pending result. The store itself is not cleared.
`include "maximum_suffix_finder_defines.svh"

module maximum_suffix_finder import msf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [7:0] char_byte
    input  logic                 i_s_axis_tlast,   // last_char
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // [11:0] start_index, [24:12] suffix_length
    output logic [M_TUSER_W-1:0] o_m_axis_tuser    // [0] overflowed
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_drop,  n_drop;
    logic               r_out_valid;
    logic [START_W-1:0] r_out_start;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_ovf;

    logic               in_acc;
    logic               has_room;
    logic               out_free;
    logic               finish;
    t_scan_ctl          scan_ctl;
    t_scan_stat         scan_stat;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [CHAR_W-1:0]  rd_data_a;
    logic [CHAR_W-1:0]  rd_data_b;
    logic [ADDR_W-1:0]  best;

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign has_room = r_count < CNT_W'(MAX_LEN);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign finish   = (r_state == ST_SCAN) && scan_stat.done && out_free;

    assign scan_ctl.start = in_acc && i_s_axis_tlast;
    assign scan_ctl.ack   = finish;

    msf_ram #(
        .DATA_W (CHAR_W),
        .DEPTH  (MAX_LEN)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (in_acc && has_room),
        .i_wr_addr   (r_count[ADDR_W-1:0]),
        .i_wr_data   (i_s_axis_tdata[CHAR_W-1:0]),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    msf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_count     (r_count),
        .o_rd_en     (rd_en),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b),
        .o_stat      (scan_stat),
        .o_best      (best)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (has_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_start <= START_W'(best);
            r_out_len   <= LEN_W'(r_count - CNT_W'(best));
            r_out_ovf   <= r_drop;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_len, r_out_start});
    assign o_m_axis_tuser  = M_TUSER_W'(r_out_ovf);

    `MSF_ASSERT_IMPLY(a_no_load_in_scan, i_clk, i_rst_n, o_s_axis_tready, !scan_stat.busy)
    `MSF_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_LEN))
    `MSF_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, scan_ctl.start, scan_stat.busy)
    `MSF_ASSERT_IMPLY(a_len_nonzero, i_clk, i_rst_n, r_out_valid, r_out_len != '0)

endmodule

[sim/tb_maximum_suffix_finder.sv]
module tb_maximum_suffix_finder import msf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int RANDOM_CHARS   = 1000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [START_W-1:0] idx;
        logic [LEN_W-1:0]   len;
        logic               ovf;
    } suffix_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // current string as the block should hold it
    logic [CHAR_W-1:0] text_mem [MAX_LEN];
    int unsigned       text_len;
    bit                text_dropped;

    suffix_res_t       expected_q [$];
    logic [CHAR_W-1:0] str_q [$];

    int  err_count;
    int  chars_sent;
    int  quiet_cycles;
    int  stall_cnt;
    int  hold_cnt;
    bit  hold_req;
    bit  idle_en;
    bit  rst_done;

    maximum_suffix_finder u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] char_byte
        .i_s_axis_tlast  (s_tlast),    // last_char
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [11:0] start_index, [24:12] suffix_length
        .o_m_axis_tuser  (m_tuser)     // [0] overflowed
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // two-pointer scan over the held string
    function automatic suffix_res_t max_suffix();
        suffix_res_t r;
        int unsigned best, probe, off, skip;
        logic [CHAR_W-1:0] a, b;
        best  = 0;
        probe = 1;
        off   = 0;
        while (probe + off < text_len) begin
            a = text_mem[best + off];
            b = text_mem[probe + off];
            if (a == b) begin
                off++;
            end else if (a < b) begin
                skip  = best + off + 1;
                best  = (skip > probe) ? skip : probe;
                probe = best + 1;
                off   = 0;
            end else begin
                probe = probe + off + 1;
                off   = 0;
            end
        end
        r.idx = best[START_W-1:0];
        r.len = LEN_W'(text_len - best);
        r.ovf = text_dropped;
        return r;
    endfunction

    function automatic void take_char(logic [CHAR_W-1:0] ch, logic last);
        if (text_len < MAX_LEN) begin
            text_mem[text_len] = ch;
            text_len++;
        end else begin
            text_dropped = 1'b1;
        end
        if (last) begin
            expected_q.push_back(max_suffix());
            text_len     = 0;
            text_dropped = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%t mismatch %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
    endfunction

    // result checking, receiver stall draw and watchdog
    always @(posedge clk) begin
        suffix_res_t e;
        if (rst_done) begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    note_mismatch("unexpected result", 0, m_tdata);
                end else begin
                    e = expected_q.pop_front();
                    if (m_tdata[START_W-1:0] !== e.idx)
                        note_mismatch("start_index", e.idx, m_tdata[START_W-1:0]);
                    if (m_tdata[START_W +: LEN_W] !== e.len)
                        note_mismatch("suffix_length", e.len, m_tdata[START_W +: LEN_W]);
                    if (m_tuser[0] !== e.ovf)
                        note_mismatch("overflowed", e.ovf, m_tuser[0]);
                end
                stall_cnt = idle_en ? $urandom_range(0, 5) : 0;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // receiver ready
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (!rst_done) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt--;
        end else if (stall_cnt > 0) begin
            m_tready <= 1'b0;
            stall_cnt--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // entered and left at a falling edge; valid stays up for a back-to-back transaction
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        take_char(ch, last);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_str();
        foreach (str_q[i])
            send_char(str_q[i], i == str_q.size() - 1);
        str_q.delete();
    endtask

    task automatic stop_input();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_directed();
        idle_en = 1'b1;
        str_q = '{8'h00};                    send_str();
        str_q = '{8'hFF};                    send_str();
        str_q = '{8'h00, 8'hFF};             send_str();
        str_q = '{8'h5A, 8'h5A, 8'h5A};      send_str();
        str_q = '{8'h03, 8'h02, 8'h01};      send_str();
        str_q = '{8'hFF, 8'h00, 8'hFF, 8'h00}; send_str();
        str_q = '{8'h7F, 8'h80, 8'h7F, 8'h80, 8'h81}; send_str();
        str_q = '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}; send_str();
        stop_input();
    endtask

    task automatic test_store_full();
        idle_en = 1'b1;
        // whole store, all equal: suffix from zero, full length
        repeat (MAX_LEN) str_q.push_back(8'hA5);
        send_str();
        // unique maximum at the last entry
        repeat (MAX_LEN - 1) str_q.push_back(CHAR_W'($urandom_range(0, 8'hFE)));
        str_q.push_back(8'hFF);
        send_str();
        // overrun: tail bytes and the final byte dropped
        repeat (MAX_LEN + 3) str_q.push_back(CHAR_W'($urandom));
        send_str();
        // next string must start clean
        str_q = '{8'h10, 8'h20};
        send_str();
        stop_input();
    endtask

    task automatic test_back_pressure();
        idle_en = 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        repeat (8) begin
            repeat ($urandom_range(1, 4)) str_q.push_back(CHAR_W'($urandom));
            send_str();
        end
        stop_input();
        idle_en = 1'b1;
    endtask

    task automatic test_random_strings();
        int kind, len, period, n_str, start_cnt;
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] pat [4];
        n_str     = 0;
        start_cnt = chars_sent;
        while (chars_sent - start_cnt < RANDOM_CHARS) begin
            if (n_str % 20 == 0)
                idle_en = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            base = CHAR_W'($urandom);
            if (kind <= 5) begin
                len = $urandom_range(1, 24);
                repeat (len) str_q.push_back(base + CHAR_W'($urandom_range(0, 2)));
            end else if (kind <= 7) begin
                period = $urandom_range(1, 4);
                foreach (pat[i]) pat[i] = base + CHAR_W'($urandom_range(0, 2));
                len = $urandom_range(period, 24);
                for (int i = 0; i < len; i++) str_q.push_back(pat[i % period]);
                if ($urandom_range(0, 1)) str_q[len - 1] = CHAR_W'($urandom);
            end else if (kind == 8) begin
                len = $urandom_range(1, 40);
                repeat (len) str_q.push_back(CHAR_W'($urandom));
            end else begin
                str_q.push_back(base);
            end
            send_str();
            n_str++;
        end
        stop_input();
        idle_en = 1'b1;
    endtask

    initial begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        text_len     = 0;
        text_dropped = 1'b0;
        err_count    = 0;
        chars_sent   = 0;
        quiet_cycles = 0;
        stall_cnt    = 0;
        hold_cnt     = 0;
        hold_req     = 1'b0;
        idle_en      = 1'b1;
        rst_done     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n    = 1'b1;
        rst_done = 1'b1;
        @(negedge clk);

        test_directed();
        test_store_full();
        test_back_pressure();
        test_random_strings();

        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[maximum_suffix_finder.f]
+incdir+rtl
rtl/msf_pkg.sv
rtl/msf_ram.sv
rtl/msf_scan.sv
rtl/maximum_suffix_finder.sv
sim/tb_maximum_suffix_finder.sv
